### rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types, codes and helpers for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int OPC_W    = 4;
    localparam int LEN_W    = 63;
    localparam int HLEN_W   = 4;
    localparam int KEY_W    = 32;
    localparam int TDATA_W  = 120;   // 116 field bits padded to whole bytes

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_RSV       = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OPCODE    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FRAG_CTRL = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NONCANON  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_LEN_MSB   = 3'd5;
    localparam logic [ERR_W-1:0] ERR_CTRL_BIG  = 3'd6;

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_CLOSE = 4'h8;
    localparam logic [OPC_W-1:0] OPC_PING  = 4'h9;
    localparam logic [OPC_W-1:0] OPC_PONG  = 4'hA;
    localparam logic [OPC_W-1:0] OPC_BINARY = 4'h2;

    // Length limits
    localparam logic [LEN_W-1:0] CTRL_MAX_LEN  = 63'd125;
    localparam logic [LEN_W-1:0] SHORT_MAX_LEN = 63'd125;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic              fin;
        logic [OPC_W-1:0]  opcode;
        logic              masked;
        logic [LEN_W-1:0]  len;
        logic [HLEN_W-1:0] hlen;
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] payload;
        logic              last;
    } result_t;

    function automatic logic is_control(input logic [OPC_W-1:0] op);
        return (op == OPC_CLOSE) || (op == OPC_PING) || (op == OPC_PONG);
    endfunction

    function automatic logic is_valid_op(input logic [OPC_W-1:0] op);
        return (op <= OPC_BINARY) || is_control(op);
    endfunction

endpackage

### rtl/wsfd_in_reg.sv
// ----------------------------------------------------------------------------
// wsfd_in_reg
// Input register: captures one stream byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module wsfd_in_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0] s_tdata,
    output logic                       byte_valid,
    output logic [wsfd_pkg::BYTE_W-1:0] byte_data,
    input  logic                       byte_take
);
    import wsfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // Free when empty or when the held byte leaves this cycle
    assign s_tready   = !valid_reg || byte_take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload load on transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

### rtl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame parse state and the single-pass decode of one byte: header fields,
// extended length, masking key, payload unmasking and error checks.
// ----------------------------------------------------------------------------
module wsfd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_fire,
    input  logic [wsfd_pkg::BYTE_W-1:0] byte_data,
    output logic                        res_valid,
    output wsfd_pkg::result_t           res
);
    import wsfd_pkg::*;

    // Parse phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       ext_cnt_reg, ext_cnt_next;
    logic             fin_reg, fin_next;
    logic [OPC_W-1:0] opc_reg, opc_next;
    logic             masked_reg, masked_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [1:0]       key_cnt_reg, key_cnt_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [1:0]       key_pos_reg, key_pos_next;

    logic             err_hit;
    logic [ERR_W-1:0] err_code;
    logic             len_done;
    logic             do_header;
    logic [LEN_W-1:0] len_val;
    logic             short_len;
    logic [BYTE_W-1:0] key_byte;

    always_comb begin
        phase_next   = phase_reg;
        ext_cnt_next = ext_cnt_reg;
        fin_next     = fin_reg;
        opc_next     = opc_reg;
        masked_next  = masked_reg;
        acc_next     = acc_reg;
        key_next     = key_reg;
        key_cnt_next = key_cnt_reg;
        remain_next  = remain_reg;
        key_pos_next = key_pos_reg;
        err_hit      = 1'b0;
        err_code     = ERR_NONE;
        len_done     = 1'b0;
        do_header    = 1'b0;
        len_val      = acc_reg;
        short_len    = 1'b0;
        key_byte     = '0;
        res_valid    = 1'b0;
        res          = '0;

        // Per-phase decode of the accepted byte
        if (byte_fire) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    masked_next = byte_data[7];
                    acc_next    = '0;
                    if (byte_data[6:0] <= 7'd125) begin
                        acc_next = {{(LEN_W-7){1'b0}}, byte_data[6:0]};
                        len_val  = acc_next;
                        len_done = 1'b1;
                    end else if (byte_data[6:0] == 7'd126) begin
                        ext_cnt_next = 3'd1;
                        phase_next   = PH_EXT16;
                    end else begin
                        ext_cnt_next = 3'd7;
                        phase_next   = PH_EXT64;
                    end
                end
                PH_EXT16: begin
                    acc_next = {{(LEN_W-16){1'b0}}, acc_reg[7:0], byte_data};
                    len_val  = acc_next;
                    if (ext_cnt_reg != 3'd0) begin
                        ext_cnt_next = ext_cnt_reg - 3'd1;
                    end else if (acc_next < 63'd126) begin
                        err_hit  = 1'b1;
                        err_code = ERR_NONCANON;
                    end else begin
                        len_done = 1'b1;
                    end
                end
                PH_EXT64: begin
                    if (ext_cnt_reg == 3'd7 && byte_data[7]) begin
                        err_hit  = 1'b1;
                        err_code = ERR_LEN_MSB;
                    end else begin
                        acc_next = {acc_reg[LEN_W-9:0], byte_data};
                        len_val  = acc_next;
                        if (ext_cnt_reg != 3'd0) begin
                            ext_cnt_next = ext_cnt_reg - 3'd1;
                        end else if (acc_next[LEN_W-1:16] == '0) begin
                            err_hit  = 1'b1;
                            err_code = ERR_NONCANON;
                        end else begin
                            len_done = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    key_next = {key_reg[KEY_W-9:0], byte_data};
                    if (key_cnt_reg != 2'd3) begin
                        key_cnt_next = key_cnt_reg + 2'd1;
                    end else begin
                        key_cnt_next = 2'd0;
                        do_header    = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    // Key byte by position, first key byte in the top bits
                    unique case (key_pos_reg)
                        2'd0:    key_byte = key_reg[31:24];
                        2'd1:    key_byte = key_reg[23:16];
                        2'd2:    key_byte = key_reg[15:8];
                        default: key_byte = key_reg[7:0];
                    endcase
                    key_pos_next = key_pos_reg + 2'd1;
                    if (remain_reg != '0) begin
                        remain_next = remain_reg - 63'd1;
                    end
                    res_valid   = 1'b1;
                    res.kind    = KIND_PAYLOAD;
                    res.payload = byte_data ^ key_byte;
                    if (remain_next == '0) begin
                        res.last   = 1'b1;
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    // First header byte
                    fin_next = byte_data[7];
                    opc_next = byte_data[3:0];
                    if (byte_data[6:4] != 3'd0) begin
                        err_hit  = 1'b1;
                        err_code = ERR_RSV;
                    end else if (!is_valid_op(byte_data[3:0])) begin
                        err_hit  = 1'b1;
                        err_code = ERR_OPCODE;
                    end else if (is_control(byte_data[3:0]) && !byte_data[7]) begin
                        err_hit  = 1'b1;
                        err_code = ERR_FRAG_CTRL;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
            endcase
        end

        // Length known: control size check, then key or header
        if (len_done) begin
            if (is_control(opc_reg) && len_val > CTRL_MAX_LEN) begin
                err_hit  = 1'b1;
                err_code = ERR_CTRL_BIG;
            end else if (masked_next) begin
                key_next     = '0;
                key_cnt_next = 2'd0;
                phase_next   = PH_KEY;
            end else begin
                key_next  = '0;
                do_header = 1'b1;
            end
        end

        // Header result
        if (do_header) begin
            short_len    = (len_val <= SHORT_MAX_LEN);
            res_valid    = 1'b1;
            res.kind     = KIND_HEADER;
            res.fin      = fin_reg;
            res.opcode   = opc_reg;
            res.masked   = masked_next;
            res.len      = len_val;
            res.hlen     = (short_len ? 4'd2 : (len_val[LEN_W-1:16] == '0) ? 4'd4 : 4'd10)
                           + (masked_next ? 4'd4 : 4'd0);
            res.key      = key_next;
            res.last     = (len_val == '0);
            remain_next  = len_val;
            key_pos_next = 2'd0;
            phase_next   = (len_val == '0) ? PH_HDR0 : PH_PAYLOAD;
        end

        // Error result, resync to a new header
        if (err_hit) begin
            res_valid  = 1'b1;
            res        = '0;
            res.kind   = KIND_ERROR;
            res.err    = err_code;
            phase_next = PH_HDR0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            ext_cnt_reg <= 3'd0;
            fin_reg     <= 1'b0;
            opc_reg     <= '0;
            masked_reg  <= 1'b0;
            acc_reg     <= '0;
            key_reg     <= '0;
            key_cnt_reg <= 2'd0;
            remain_reg  <= '0;
            key_pos_reg <= 2'd0;
        end else begin
            phase_reg   <= phase_next;
            ext_cnt_reg <= ext_cnt_next;
            fin_reg     <= fin_next;
            opc_reg     <= opc_next;
            masked_reg  <= masked_next;
            acc_reg     <= acc_next;
            key_reg     <= key_next;
            key_cnt_reg <= key_cnt_next;
            remain_reg  <= remain_next;
            key_pos_reg <= key_pos_next;
        end
    end

endmodule

### rtl/wsfd_out_skid.sv
// ----------------------------------------------------------------------------
// wsfd_out_skid
// Result register with a skid entry; the ready toward the parser comes
// from a register, so out_ready has no combinational path to the input side.
// ----------------------------------------------------------------------------
module wsfd_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wsfd_pkg::result_t push_res,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfd_pkg::result_t out_res
);
    import wsfd_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    spare_valid_reg, spare_valid_next;
    result_t main_reg;
    result_t spare_reg;
    logic    pop;
    logic    load_main;
    logic    load_spare;
    logic    shift_spare;

    assign push_ready = !spare_valid_reg;
    assign pop        = main_valid_reg && out_ready;

    // Occupancy control
    always_comb begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        load_main        = 1'b0;
        load_spare       = 1'b0;
        shift_spare      = 1'b0;
        if (spare_valid_reg) begin
            if (pop) begin
                shift_spare      = 1'b1;
                spare_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end else begin
                load_spare       = 1'b1;
                spare_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (shift_spare) begin
            main_reg <= spare_reg;
        end else if (load_main) begin
            main_reg <= push_res;
        end
        if (load_spare) begin
            spare_reg <= push_res;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

### rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket (RFC 6455) frame parser: header decode, payload unmasking and
// protocol error reporting on a byte stream.
// ----------------------------------------------------------------------------
// Takes one stream byte per transfer and sustains one byte per clock while
// the master side accepts results. Each byte passes through an input
// register, a combinational decode against the parse state, and a result
// register with a skid entry, from which its result is valid on the master
// side; only master-side back-pressure holds results back, and once the skid
// entry is full the input side stalls. Header bytes that
// do not complete a header give no result; the byte that completes one gives
// a header result (tuser 0), each payload byte gives its unmasked value
// (tuser 1), and a protocol error gives an error result (tuser 2), after
// which the next byte is taken as the start of a new header. tlast marks the
// last payload byte of a frame, or the header of an empty frame.
module websocket_frame_deframer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wsfd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] error_code, [3] final_flag, [7:4] frame_opcode, [8] mask_present,
    // [71:9] payload_length, [75:72] header_length, [107:76] mask_word,
    // [115:108] payload_out, [119:116] zero
    output logic [wsfd_pkg::TDATA_W-1:0]  m_tdata,
    output logic [wsfd_pkg::KIND_W-1:0]   m_tuser,   // [1:0] result_kind
    output logic                          m_tlast    // last_of_frame
);
    import wsfd_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              byte_fire;
    logic              res_valid;
    result_t           res;
    logic              push_ready;
    result_t           out_res;

    assign byte_fire = byte_valid && push_ready;

    // Input register
    wsfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_fire)
    );

    // Decode
    wsfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    wsfd_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_res   (res),
        .push_ready (push_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    // Result packing
    assign m_tdata = {4'd0, out_res.payload, out_res.key, out_res.hlen, out_res.len,
                      out_res.masked, out_res.opcode, out_res.fin, out_res.err};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
